>>> hdl/ivr_pkg.sv
// shared types and constants of the int8 vector reduction block
package ivr_pkg;

  localparam int unsigned ElemW  = 8;
  localparam int unsigned ProdW  = 2 * ElemW;
  localparam int unsigned SumW   = 32;
  localparam int unsigned FracW  = 16;
  localparam int unsigned RootW  = SumW + FracW;
  localparam int unsigned CfgIdxW = 2;

  // first trial bit of the shift-subtract square root
  localparam logic [RootW-1:0] RootFirstBit = RootW'(1) << (RootW - 2);

  typedef enum logic [1:0] {
    MODE_DOT      = 2'd0,
    MODE_NORM     = 2'd1,
    MODE_ALL_EQ   = 2'd2,
    MODE_ALL_DIFF = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE      = 2'd0,
    REG_USE_CONST = 2'd1,
    REG_CONST_OP  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ST_ACCUM = 1'b0,
    ST_ROOT  = 1'b1
  } state_e;

  typedef struct packed {
    logic acc;          // element accepted, accumulate it
    logic load_direct;  // last element, result ready at once
    logic root_start;   // last element in norm mode, start the root
    logic root_step;    // one root iteration
    logic load_root;    // root finished, move it to the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic mode_norm;
    logic root_done;
  } dp_status_t;

endpackage

>>> hdl/ivr_if.sv
// handshake channels of the int8 vector reduction block
interface ivr_elem_if;
  logic                               valid;
  logic                               ready;
  logic signed [ivr_pkg::ElemW-1:0]   element_a;
  logic signed [ivr_pkg::ElemW-1:0]   element_b;
  logic                               last_element;

  modport source (output valid, element_a, element_b, last_element, input ready);
  modport sink   (input valid, element_a, element_b, last_element, output ready);
endinterface

interface ivr_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [ivr_pkg::SumW-1:0]    sum_result;
  logic                               compare_true;

  modport source (output valid, sum_result, compare_true, input ready);
  modport sink   (input valid, sum_result, compare_true, output ready);
endinterface

interface ivr_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ivr_pkg::CfgIdxW-1:0]        reg_index;
  logic [ivr_pkg::ElemW-1:0]          write_data;

  modport source (output valid, reg_index, write_data, input ready);
  modport sink   (input valid, reg_index, write_data, output ready);
endinterface

>>> hdl/int8_vector_reduction_core.sv
// top level of the int8 vector reduction block
//
//  channel   dir  handshake      payload
//  elem_i    in   valid/ready    element_a, element_b, last_element
//  res_o     out  valid/ready    sum_result, compare_true
//  cfg_i     in   valid/ready    reg_index, write_data (ready always high)
//
// one element per cycle while a vector streams in; dot and compare results
// reach the result register on the cycle after the last element
// norm mode adds 24 root steps and one load, with elem_i.ready low
// reset: mode dot, use_constant 0, constant 0, accumulators cleared
// res_o stalls hold a dot or compare last element, or a finished root with
// elem_i.ready low, never the rest of a vector
module int8_vector_reduction_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  ivr_elem_if.sink   elem_i,
  ivr_res_if.source  res_o,
  ivr_cfg_if.sink    cfg_i
);

  ivr_pkg::ctrl_cmd_t  cmd;
  ivr_pkg::dp_status_t status;

  assign cfg_i.ready = 1'b1;

  ivr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (elem_i.valid),
    .in_last_i   (elem_i.last_element),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .in_ready_o  (elem_i.ready),
    .out_valid_o (res_o.valid),
    .cmd_o       (cmd)
  );

  ivr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .element_a_i    (elem_i.element_a),
    .element_b_i    (elem_i.element_b),
    .cfg_we_i       (cfg_i.valid),
    .cfg_index_i    (cfg_i.reg_index),
    .cfg_data_i     (cfg_i.write_data),
    .cmd_i          (cmd),
    .status_o       (status),
    .sum_result_o   (res_o.sum_result),
    .compare_true_o (res_o.compare_true)
  );

  // at most one of the sequencing commands per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_direct, cmd.root_start, cmd.root_step, cmd.load_root}))
    else $error("conflicting datapath commands");

  // a result is never written over one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_direct || cmd.load_root) |-> (!res_o.valid || res_o.ready))
    else $error("result register overwritten");

  // no element is taken while the square root runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.root_step |-> !elem_i.ready)
    else $error("element accepted during root");

  // starting the root leaves work to do on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.root_start |=> (!status.root_done && !elem_i.ready))
    else $error("root finished without iterating");

endmodule

>>> hdl/ivr_ctrl.sv
// controller: accumulate / square root sequencing and result register valid
module ivr_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_last_i,
  input  logic                   out_ready_i,
  input  ivr_pkg::dp_status_t    status_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  output ivr_pkg::ctrl_cmd_t     cmd_o
);

  ivr_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ivr_pkg::ST_ACCUM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    // result register empty, or being emptied this cycle
    slot_free  = !out_valid_q || out_ready_i;

    case (state_q)
      ivr_pkg::ST_ACCUM: begin
        // only a last item that finishes at once needs the result slot
        in_ready_o = !in_last_i || status_i.mode_norm || slot_free;
        if (in_valid_i && in_ready_o) begin
          cmd_o.acc = 1'b1;
          if (in_last_i) begin
            if (status_i.mode_norm) begin
              cmd_o.root_start = 1'b1;
              state_d          = ivr_pkg::ST_ROOT;
            end else begin
              cmd_o.load_direct = 1'b1;
            end
          end
        end
      end
      ivr_pkg::ST_ROOT: begin
        if (!status_i.root_done) begin
          cmd_o.root_step = 1'b1;
        end else if (slot_free) begin
          cmd_o.load_root = 1'b1;
          state_d         = ivr_pkg::ST_ACCUM;
        end
      end
      default: begin
        state_d = ivr_pkg::ST_ACCUM;
      end
    endcase

    out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.load_direct || cmd_o.load_root;
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/ivr_datapath.sv
// datapath: config registers, multiply-accumulate, match flag, square root, result register
module ivr_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [ivr_pkg::ElemW-1:0]    element_a_i,
  input  logic signed [ivr_pkg::ElemW-1:0]    element_b_i,
  input  logic                                cfg_we_i,
  input  logic [ivr_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [ivr_pkg::ElemW-1:0]           cfg_data_i,
  input  ivr_pkg::ctrl_cmd_t                  cmd_i,
  output ivr_pkg::dp_status_t                 status_o,
  output logic signed [ivr_pkg::SumW-1:0]     sum_result_o,
  output logic                                compare_true_o
);

  ivr_pkg::mode_e                     mode_q;
  logic                               use_const_q;
  logic signed [ivr_pkg::ElemW-1:0]   const_op_q;

  logic [ivr_pkg::SumW-1:0]           running_sum_q;
  logic                               all_match_q;

  logic [ivr_pkg::RootW-1:0]          rem_q, root_q, bit_q;
  logic [ivr_pkg::RootW-1:0]          trial;

  logic signed [ivr_pkg::SumW-1:0]    sum_q;
  logic                               cmp_q;

  logic signed [ivr_pkg::ElemW-1:0]   mul_b;
  logic signed [ivr_pkg::ElemW-1:0]   partner;
  logic signed [ivr_pkg::ProdW-1:0]   prod;
  logic [ivr_pkg::SumW-1:0]           sum_next;
  logic                               match_next;
  logic                               clear;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ivr_pkg::MODE_DOT;
      use_const_q <= 1'b0;
      const_op_q  <= '0;
    end else if (cfg_we_i) begin
      case (ivr_pkg::cfg_reg_e'(cfg_index_i))
        ivr_pkg::REG_MODE:      mode_q      <= ivr_pkg::mode_e'(cfg_data_i[1:0]);
        ivr_pkg::REG_USE_CONST: use_const_q <= cfg_data_i[0];
        ivr_pkg::REG_CONST_OP:  const_op_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // element arithmetic
  always_comb begin
    mul_b   = (mode_q == ivr_pkg::MODE_NORM) ? element_a_i : element_b_i;
    partner = use_const_q ? const_op_q : element_b_i;
    prod    = element_a_i * mul_b;

    case (mode_q)
      ivr_pkg::MODE_DOT, ivr_pkg::MODE_NORM: begin
        sum_next   = running_sum_q + {{(ivr_pkg::SumW - ivr_pkg::ProdW){prod[ivr_pkg::ProdW-1]}},
                                      prod};
        match_next = all_match_q;
      end
      ivr_pkg::MODE_ALL_EQ: begin
        sum_next   = running_sum_q;
        match_next = all_match_q && (element_a_i == partner);
      end
      default: begin
        sum_next   = running_sum_q;
        match_next = all_match_q && (element_a_i != partner);
      end
    endcase

    clear = cmd_i.load_direct || cmd_i.root_start;
    trial = root_q + bit_q;
  end

  // accumulators, back to reset value at the end of each vector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_sum_q <= '0;
      all_match_q   <= 1'b1;
    end else if (cmd_i.acc) begin
      if (clear) begin
        running_sum_q <= '0;
        all_match_q   <= 1'b1;
      end else begin
        running_sum_q <= sum_next;
        all_match_q   <= match_next;
      end
    end
  end

  // shift-subtract square root, one result bit per step
  always_ff @(posedge clk_i) begin
    if (cmd_i.root_start) begin
      rem_q  <= {sum_next, {ivr_pkg::FracW{1'b0}}};
      root_q <= '0;
      bit_q  <= ivr_pkg::RootFirstBit;
    end else if (cmd_i.root_step) begin
      if (rem_q >= trial) begin
        rem_q  <= rem_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_direct) begin
      sum_q <= (mode_q == ivr_pkg::MODE_DOT) ? sum_next : '0;
      cmp_q <= (mode_q inside {ivr_pkg::MODE_ALL_EQ, ivr_pkg::MODE_ALL_DIFF}) ? match_next
                                                                               : 1'b0;
    end else if (cmd_i.load_root) begin
      sum_q <= root_q[ivr_pkg::SumW-1:0];
      cmp_q <= 1'b0;
    end
  end

  assign status_o.mode_norm = (mode_q == ivr_pkg::MODE_NORM);
  assign status_o.root_done = (bit_q == '0);
  assign sum_result_o       = sum_q;
  assign compare_true_o     = cmp_q;

endmodule
